FILE: hw/rtl/mime_boundary_extractor_defines.svh
// assertion macros used by the checker file of the boundary extractor
// no dependencies; clk and rst must be visible where the macros are used
`ifndef MIME_BOUNDARY_EXTRACTOR_DEFINES_SVH
`define MIME_BOUNDARY_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbe check failed");

// next-cycle implication, disabled during reset
`define MBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbe check failed");

`endif

FILE: hw/rtl/mbe_pkg.sv
// constants, phase codes and helper functions for the boundary extractor
// no dependencies
`default_nettype none

package mbe_pkg;

  localparam int ByteW  = 8;
  localparam int PosW   = 4;
  localparam int PhaseW = 2;
  localparam int KeyLen = 9;

  // parse phases
  localparam logic [PhaseW-1:0] PH_SEEK_MULTI = 2'd0;
  localparam logic [PhaseW-1:0] PH_SEEK_BOUND = 2'd1;
  localparam logic [PhaseW-1:0] PH_VALUE      = 2'd2;
  localparam logic [PhaseW-1:0] PH_DONE       = 2'd3;

  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3b;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0d;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0a;
  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;

  // "multipart"
  function automatic logic [ByteW-1:0] key_multi(input logic [PosW-1:0] pos);
    logic [ByteW-1:0] c;
    unique case (pos)
      4'd0:    c = "m";
      4'd1:    c = "u";
      4'd2:    c = "l";
      4'd3:    c = "t";
      4'd4:    c = "i";
      4'd5:    c = "p";
      4'd6:    c = "a";
      4'd7:    c = "r";
      4'd8:    c = "t";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // "boundary="
  function automatic logic [ByteW-1:0] key_bound(input logic [PosW-1:0] pos);
    logic [ByteW-1:0] c;
    unique case (pos)
      4'd0:    c = "b";
      4'd1:    c = "o";
      4'd2:    c = "u";
      4'd3:    c = "n";
      4'd4:    c = "d";
      4'd5:    c = "a";
      4'd6:    c = "r";
      4'd7:    c = "y";
      4'd8:    c = "=";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [ByteW-1:0] fold_case(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic is_terminator(input logic [ByteW-1:0] c);
    return c == CH_SEMI || c == CH_CR || c == CH_LF || c == CH_SPACE || c == CH_NUL;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mbe_if.sv
// stream interfaces for header bytes in and boundary results out
// depends on mbe_pkg
`default_nettype none

interface mbe_hdr_if import mbe_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] header_byte;
  logic             last_byte;

  modport source (output valid, header_byte, last_byte, input ready);
  modport sink   (input valid, header_byte, last_byte, output ready);
endinterface

interface mbe_bnd_if import mbe_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] boundary_byte;
  logic             byte_valid;
  logic             boundary_done;
  logic             boundary_found;

  modport source (output valid, boundary_byte, byte_valid, boundary_done, boundary_found,
                  input ready);
  modport sink   (input valid, boundary_byte, byte_valid, boundary_done, boundary_found,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mime_boundary_extractor.sv
// mime multipart boundary extractor: header bytes in, boundary bytes out
// an accepted header beat's result is registered and is valid in the cycle after it is taken
// throughput: one beat per cycle while the output is not stalled, set by the single output register
// a new beat is taken whenever the output register is empty or being drained
// reset (rst, synchronous): back to the multipart search, output register empty
// depends on mbe_pkg and mbe_if
`default_nettype none

module mime_boundary_extractor import mbe_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  mbe_hdr_if.sink      header,
  mbe_bnd_if.source    boundary
);

  // parser state
  logic [PhaseW-1:0] phase;
  logic [PosW-1:0]   match_position;
  logic              prev_sep;

  logic [PhaseW-1:0] phase_next;
  logic [PosW-1:0]   match_position_next;
  logic              prev_sep_next;

  // result of the beat at the input
  logic [ByteW-1:0]  res_byte;
  logic              res_valid;
  logic              res_done;
  logic              res_found;

  // output register
  logic              out_valid;
  logic [ByteW-1:0]  out_byte;
  logic              out_bvalid;
  logic              out_done;
  logic              out_found;

  logic              accept;
  logic [ByteW-1:0]  c;
  logic [ByteW-1:0]  lc;
  logic [PosW-1:0]   pos;

  // take a beat whenever the output slot frees up this cycle
  assign header.ready = !out_valid || boundary.ready;
  assign accept       = header.valid && header.ready;

  assign c  = header.header_byte;
  assign lc = fold_case(c);

  always_comb begin
    phase_next = phase;
    pos        = match_position;
    res_byte   = '0;
    res_valid  = 1'b0;
    res_done   = 1'b0;
    res_found  = 1'b0;

    unique case (phase)
      PH_SEEK_MULTI: begin
        // a failed match restarts at this byte
        if (pos < PosW'(KeyLen) && lc == key_multi(pos)) begin
          pos = pos + 4'd1;
        end else begin
          pos = (lc == key_multi(4'd0)) ? 4'd1 : 4'd0;
        end
        if (pos >= PosW'(KeyLen)) begin
          phase_next = PH_SEEK_BOUND;
          pos        = '0;
        end
      end
      PH_SEEK_BOUND: begin
        // the keyword may only start right after a space or semicolon
        if (pos == 4'd0) begin
          if (lc == key_bound(4'd0) && prev_sep) begin
            pos = 4'd1;
          end
        end else if (pos < PosW'(KeyLen) && lc == key_bound(pos)) begin
          pos = pos + 4'd1;
        end else begin
          pos = (lc == key_bound(4'd0) && prev_sep) ? 4'd1 : 4'd0;
        end
        if (pos >= PosW'(KeyLen)) begin
          phase_next = PH_VALUE;
          pos        = '0;
          res_found  = 1'b1;
          res_done   = header.last_byte;
        end
      end
      PH_VALUE: begin
        res_found = 1'b1;
        if (is_terminator(c)) begin
          res_done   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          // quotes are dropped, everything else passes unchanged
          if (c != CH_QUOTE) begin
            res_byte  = c;
            res_valid = 1'b1;
          end
          res_done = header.last_byte;
        end
      end
      PH_DONE: begin
        res_found = 1'b1;
      end
    endcase

    match_position_next = pos;
    prev_sep_next       = (c == CH_SPACE) || (c == CH_SEMI);

    // end of header: start over for the next one
    if (header.last_byte) begin
      phase_next          = PH_SEEK_MULTI;
      match_position_next = '0;
      prev_sep_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SEEK_MULTI;
      match_position <= '0;
      prev_sep       <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      match_position <= match_position_next;
      prev_sep       <= prev_sep_next;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (boundary.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte   <= res_byte;
      out_bvalid <= res_valid;
      out_done   <= res_done;
      out_found  <= res_found;
    end
  end

  assign boundary.valid          = out_valid;
  assign boundary.boundary_byte  = out_byte;
  assign boundary.byte_valid     = out_bvalid;
  assign boundary.boundary_done  = out_done;
  assign boundary.boundary_found = out_found;

endmodule

`default_nettype wire

FILE: hw/rtl/mbe_checker.sv
// port-level checks for the boundary extractor, bound to the top level
// depends on mbe_pkg, mime_boundary_extractor_defines.svh and mime_boundary_extractor
`default_nettype none

`include "mime_boundary_extractor_defines.svh"

module mbe_checker import mbe_pkg::*; (
  input wire             clk,
  input wire             rst,
  input wire             out_valid,
  input wire             out_ready,
  input wire [ByteW-1:0] boundary_byte,
  input wire             byte_valid,
  input wire             boundary_done,
  input wire             boundary_found
);

  // a stalled result beat stays put
  `MBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(boundary_byte) && $stable(byte_valid))

  // value bytes and the end mark only come after the keyword matched
  `MBE_ASSERT_NOW(a_byte_needs_found, out_valid && byte_valid, boundary_found)
  `MBE_ASSERT_NOW(a_done_needs_found, out_valid && boundary_done, boundary_found)

  // quotes and terminators never leave as value bytes
  `MBE_ASSERT_NOW(a_byte_clean, out_valid && byte_valid,
                  boundary_byte != CH_QUOTE && boundary_byte != CH_SEMI &&
                  boundary_byte != CH_SPACE && boundary_byte != CH_CR &&
                  boundary_byte != CH_LF && boundary_byte != CH_NUL)

endmodule

bind mime_boundary_extractor mbe_checker u_mbe_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (boundary.valid),
  .out_ready      (boundary.ready),
  .boundary_byte  (boundary.boundary_byte),
  .byte_valid     (boundary.byte_valid),
  .boundary_done  (boundary.boundary_done),
  .boundary_found (boundary.boundary_found)
);

`default_nettype wire
